FILE: sv/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
// no dependencies; imported by i2cm_engine and i2c_master_byte_engine_core
`default_nettype none

package i2cm_pkg;

  localparam int CFG_W          = 16;
  localparam int CNT_W_DEF      = 16;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 4;
  localparam int ACT_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam logic [CFG_W-1:0] PHASE_TICKS_RST   = 16'd5;
  localparam logic [CFG_W-1:0] STRETCH_LIMIT_RST = 16'd50;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // register indexes
  localparam logic REG_PHASE_TICKS   = 1'b0;
  localparam logic REG_STRETCH_LIMIT = 1'b1;

  // command codes
  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_START = 3'd1;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BUS_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NACK    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    STEP_IDLE    = 4'd0,
    STEP_ST_REL  = 4'd1,
    STEP_ST_HIGH = 4'd2,
    STEP_ST_SDA  = 4'd3,
    STEP_SP_LOW  = 4'd4,
    STEP_SP_HIGH = 4'd5,
    STEP_WR_LOW  = 4'd6,
    STEP_WR_HIGH = 4'd7,
    STEP_WA_LOW  = 4'd8,
    STEP_WA_HIGH = 4'd9,
    STEP_RD_LOW  = 4'd10,
    STEP_RD_HIGH = 4'd11,
    STEP_RK_LOW  = 4'd12,
    STEP_RK_HIGH = 4'd13,
    STEP_TAIL    = 4'd14
  } step_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              scl_in;
    logic              sda_in;
  } item_t;

  typedef struct packed {
    logic                scl_low;
    logic                sda_low;
    logic                busy;
    logic                done;
    logic [BYTE_W-1:0]   rx_byte;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/i2cm_engine.sv
// bus sequencer of the i2c master: state, counters and shifter, one tick per enable
// depends on i2cm_pkg
`default_nettype none

module i2cm_engine #(
  parameter int COUNT_WIDTH = i2cm_pkg::CNT_W_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             en_i,
  input  wire i2cm_pkg::item_t            item_i,
  input  wire [i2cm_pkg::CFG_W-1:0]       phase_ticks_i,
  input  wire [i2cm_pkg::CFG_W-1:0]       stretch_limit_i,
  output i2cm_pkg::res_t                  res_o
);
  import i2cm_pkg::*;

  localparam int EW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  step_e                 step_q, step_d;
  logic [BIT_CNT_W-1:0]  bc_q, bc_d, bc_inc;
  logic [BYTE_W-1:0]     sr_q, sr_d, sr_wr, sr_rd;
  logic [COUNT_WIDTH-1:0] pc_q, pc_d, pc_inc;
  logic [COUNT_WIDTH-1:0] sc_q, sc_d, sc_inc;
  logic [STATUS_W-1:0]   stat_q, stat_d;
  logic                  scl_q, scl_d, sda_q, sda_d;
  logic                  ack_q, ack_d;
  logic [BYTE_W-1:0]     rx_q, rx_d;
  logic                  done;
  logic                  go;
  logic                  high;

  logic [EW-1:0]          ph_ext, lim_ext, mask_ext, ph_eff, lim_eff;
  logic [COUNT_WIDTH-1:0] p_eff, l_eff;
  logic [BIT_CNT_W-1:0]   cut_sh;
  logic [2*BYTE_W-1:0]    cut_w;

  // effective phase and stretch limits: zero acts as one, clamp to counter range
  always_comb begin
    ph_ext   = EW'(phase_ticks_i);
    lim_ext  = EW'(stretch_limit_i);
    mask_ext = EW'({COUNT_WIDTH{1'b1}});
    if (ph_ext == '0) begin
      ph_eff = EW'(1);
    end else if (ph_ext > mask_ext) begin
      ph_eff = mask_ext;
    end else begin
      ph_eff = ph_ext;
    end
    if (lim_ext == '0) begin
      lim_eff = EW'(1);
    end else if (lim_ext > mask_ext) begin
      lim_eff = mask_ext;
    end else begin
      lim_eff = lim_ext;
    end
    p_eff = ph_eff[COUNT_WIDTH-1:0];
    l_eff = lim_eff[COUNT_WIDTH-1:0];
  end

  assign pc_inc = (pc_q == {COUNT_WIDTH{1'b1}}) ? pc_q : pc_q + 1'b1;
  assign sc_inc = (sc_q == {COUNT_WIDTH{1'b1}}) ? sc_q : sc_q + 1'b1;
  assign bc_inc = bc_q + 1'b1;
  assign sr_wr  = {sr_q[BYTE_W-2:0], 1'b0};
  assign sr_rd  = {sr_q[BYTE_W-2:0], item_i.sda_in};
  assign cut_sh = BITS_PER_BYTE - bc_q;
  assign cut_w  = {{BYTE_W{1'b0}}, sr_q} << cut_sh;

  assign high = (step_q == STEP_ST_HIGH) || (step_q == STEP_SP_HIGH) ||
                (step_q == STEP_WR_HIGH) || (step_q == STEP_WA_HIGH) ||
                (step_q == STEP_RD_HIGH) || (step_q == STEP_RK_HIGH);

  always_comb begin
    step_d = step_q;
    bc_d   = bc_q;
    sr_d   = sr_q;
    pc_d   = pc_q;
    sc_d   = sc_q;
    stat_d = stat_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    ack_d  = ack_q;
    rx_d   = rx_q;
    done   = 1'b0;
    go     = 1'b0;

    if (step_q == STEP_IDLE) begin
      if (item_i.action == ACT_START || item_i.action == ACT_STOP ||
          item_i.action == ACT_WRITE || item_i.action == ACT_READ) begin
        stat_d = STAT_OK;
        bc_d   = '0;
        go     = 1'b1;
        unique case (item_i.action)
          ACT_START: begin
            step_d = STEP_ST_REL;
            sda_d  = 1'b0;
          end
          ACT_STOP: begin
            step_d = STEP_SP_LOW;
            scl_d  = 1'b1;
            sda_d  = 1'b1;
          end
          ACT_WRITE: begin
            sr_d   = item_i.tx_byte;
            step_d = STEP_WR_LOW;
            scl_d  = 1'b1;
            sda_d  = ~item_i.tx_byte[BYTE_W-1];
          end
          default: begin
            ack_d  = item_i.send_ack;
            sr_d   = '0;
            step_d = STEP_RD_LOW;
            scl_d  = 1'b1;
            sda_d  = 1'b0;
          end
        endcase
      end
    end else if (!high) begin
      pc_d = pc_inc;
      if (pc_inc >= p_eff) begin
        go = 1'b1;
        unique case (step_q)
          STEP_ST_REL: begin
            step_d = STEP_ST_HIGH; scl_d = 1'b0; sda_d = 1'b0;
          end
          STEP_ST_SDA: begin
            step_d = STEP_TAIL; scl_d = 1'b1; sda_d = 1'b1;
          end
          STEP_SP_LOW: begin
            step_d = STEP_SP_HIGH; scl_d = 1'b0; sda_d = 1'b1;
          end
          STEP_WR_LOW: begin
            step_d = STEP_WR_HIGH; scl_d = 1'b0;
          end
          STEP_WA_LOW: begin
            step_d = STEP_WA_HIGH; scl_d = 1'b0; sda_d = 1'b0;
          end
          STEP_RD_LOW: begin
            step_d = STEP_RD_HIGH; scl_d = 1'b0; sda_d = 1'b0;
          end
          STEP_RK_LOW: begin
            step_d = STEP_RK_HIGH; scl_d = 1'b0;
          end
          default: begin
            step_d = STEP_IDLE;
            done   = 1'b1;
          end
        endcase
      end
    end else if (item_i.scl_in) begin
      sc_d = '0;
      pc_d = pc_inc;
      if (pc_inc >= p_eff) begin
        go = 1'b1;
        unique case (step_q)
          STEP_ST_HIGH: begin
            step_d = STEP_ST_SDA; scl_d = 1'b0; sda_d = 1'b1;
          end
          STEP_SP_HIGH: begin
            step_d = STEP_TAIL; scl_d = 1'b0; sda_d = 1'b0;
          end
          STEP_WR_HIGH: begin
            sr_d  = sr_wr;
            bc_d  = bc_inc;
            scl_d = 1'b1;
            if (bc_inc >= BITS_PER_BYTE) begin
              step_d = STEP_WA_LOW; sda_d = 1'b0;
            end else begin
              step_d = STEP_WR_LOW; sda_d = ~sr_wr[BYTE_W-1];
            end
          end
          STEP_WA_HIGH: begin
            if (item_i.sda_in) begin
              stat_d = STAT_NACK;
            end
            step_d = STEP_TAIL; scl_d = 1'b1; sda_d = 1'b0;
          end
          STEP_RD_HIGH: begin
            sr_d  = sr_rd;
            bc_d  = bc_inc;
            scl_d = 1'b1;
            if (bc_inc >= BITS_PER_BYTE) begin
              rx_d   = sr_rd;
              step_d = STEP_RK_LOW;
              sda_d  = ack_q;
            end else begin
              step_d = STEP_RD_LOW;
              sda_d  = 1'b0;
            end
          end
          default: begin
            step_d = STEP_TAIL; scl_d = 1'b1; sda_d = 1'b0;
          end
        endcase
      end
    end else begin
      sc_d = sc_inc;
      if (sc_inc >= l_eff) begin
        go     = 1'b1;
        stat_d = STAT_BUS_ERR;
        step_d = STEP_TAIL;
        if (step_q == STEP_ST_HIGH || step_q == STEP_SP_HIGH) begin
          scl_d = 1'b0;
          sda_d = 1'b0;
        end else begin
          if (step_q == STEP_RD_HIGH && bc_q < BITS_PER_BYTE) begin
            rx_d = cut_w[BYTE_W-1:0];
          end
          scl_d = 1'b1;
        end
      end
    end

    if (go) begin
      pc_d = '0;
      sc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      bc_q   <= '0;
      sr_q   <= '0;
      pc_q   <= '0;
      sc_q   <= '0;
      stat_q <= STAT_OK;
      scl_q  <= 1'b0;
      sda_q  <= 1'b0;
      ack_q  <= 1'b0;
      rx_q   <= '0;
    end else if (en_i) begin
      step_q <= step_d;
      bc_q   <= bc_d;
      sr_q   <= sr_d;
      pc_q   <= pc_d;
      sc_q   <= sc_d;
      stat_q <= stat_d;
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      ack_q  <= ack_d;
      rx_q   <= rx_d;
    end
  end

  always_comb begin
    res_o.scl_low = scl_d;
    res_o.sda_low = sda_d;
    res_o.busy    = (step_d != STEP_IDLE);
    res_o.done    = done;
    res_o.rx_byte = rx_d;
    res_o.status  = stat_d;
  end

endmodule

`default_nettype wire

FILE: sv/i2c_master_byte_engine_core.sv
// top level of the i2c master byte engine: apb registers, input and result registers
// depends on i2cm_pkg and i2cm_engine
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   action, tx_byte, send_ack, scl_in, sda_in
//   out      output     out_valid_o / out_stall_i scl_low, sda_low, busy_res, done_res,
//                                                 rx_byte, status
//   apb      input      psel / penable / pready   paddr, pwdata, prdata
//
// one tick per cycle while the result register is not stalled
// the sequencer updates once per tick between the input register and the result register
// reset: phase_ticks 5, stretch_limit 50, sequencer idle, both lines released
// a stalled result holds the result register, which stalls the input register behind it
`default_nettype none

module i2c_master_byte_engine_core #(
  parameter int COUNT_WIDTH = i2cm_pkg::CNT_W_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [i2cm_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire [i2cm_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire [i2cm_pkg::ACT_W-1:0]            action_i,
  input  wire [i2cm_pkg::BYTE_W-1:0]           tx_byte_i,
  input  wire                                  send_ack_i,
  input  wire                                  scl_in_i,
  input  wire                                  sda_in_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 scl_low_o,
  output logic                                 sda_low_o,
  output logic                                 busy_res_o,
  output logic                                 done_res_o,
  output logic [i2cm_pkg::BYTE_W-1:0]          rx_byte_o,
  output logic [i2cm_pkg::STATUS_W-1:0]        status_o
);
  import i2cm_pkg::*;

  logic [CFG_W-1:0] phase_q, limit_q;
  logic             reg_idx;
  logic             cfg_wr;

  logic  in_vld_q;
  item_t item_q;
  logic  out_vld_q;
  res_t  res_q;
  res_t  res_nxt;
  logic  adv;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_TICKS: prdata = APB_DATA_W'(phase_q);
      default:         prdata = APB_DATA_W'(limit_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_TICKS_RST;
      limit_q <= STRETCH_LIMIT_RST;
    end else if (cfg_wr) begin
      if (reg_idx == REG_PHASE_TICKS) begin
        phase_q <= pwdata[CFG_W-1:0];
      end else begin
        limit_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.action   <= action_i;
      item_q.tx_byte  <= tx_byte_i;
      item_q.send_ack <= send_ack_i;
      item_q.scl_in   <= scl_in_i;
      item_q.sda_in   <= sda_in_i;
    end
  end

  i2cm_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .item_i          (item_q),
    .phase_ticks_i   (phase_q),
    .stretch_limit_i (limit_q),
    .res_o           (res_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_nxt;
    end
  end

  assign out_valid_o = out_vld_q;
  assign scl_low_o   = res_q.scl_low;
  assign sda_low_o   = res_q.sda_low;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign rx_byte_o   = res_q.rx_byte;
  assign status_o    = res_q.status;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done pulse while still busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != STAT_UNUSED)
    else $error("undefined status code");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && out_stall_i)
    else $error("input stalled without a stalled result");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("tick processed but no result held");
`endif

endmodule

`default_nettype wire
